[rtl/core/hdrbg_pkg.sv]
// package: constants, types and sha-256 helpers for the hmac drbg block
package hdrbg_pkg;

  localparam int SeedBytes   = 256;
  localparam int SeedAw      = $clog2(SeedBytes);
  localparam int SeedCw      = SeedAw + 1;
  localparam int MaxOutBytes = 512;
  localparam int LenW        = 10;

  typedef enum logic [1:0] {
    REQ_INST = 2'd0,
    REQ_RESEED = 2'd1,
    REQ_GEN = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  // request from the sequencer to the sha core
  typedef struct packed {
    logic        start;
    logic        init;
    logic [511:0] block;
  } sha_req_t;

  typedef struct packed {
    logic         done;
    logic [255:0] digest;
  } sha_rsp_t;

  localparam logic [255:0] Iv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

endpackage

[rtl/core/hdrbg_sha_core.sv]
// sha-256 compression engine, one round per cycle
module hdrbg_sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hdrbg_pkg::sha_req_t req_i,
  output hdrbg_pkg::sha_rsp_t rsp_o
);
  import hdrbg_pkg::*;

  logic [255:0] h_q, h_d;
  logic [31:0]  s_q [8];
  logic [31:0]  s_d [8];
  logic [31:0]  w_q [16];
  logic [31:0]  w_d [16];
  logic [5:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [31:0]  t1, t2, s0w, s1w, wn;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    t1 = s_q[7] + (rr(s_q[4], 6) ^ rr(s_q[4], 11) ^ rr(s_q[4], 25)) +
         ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) + round_k(rnd_q) + w_q[0];
    t2 = (rr(s_q[0], 2) ^ rr(s_q[0], 13) ^ rr(s_q[0], 22)) +
         ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
    s0w = rr(w_q[1], 7) ^ rr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1w = rr(w_q[14], 17) ^ rr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = s1w + w_q[9] + s0w + w_q[0];
    h_d = h_q;
    s_d = s_q;
    w_d = w_q;
    rnd_d = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      if (req_i.init) h_d = Iv;
      for (int i = 0; i < 8; i++) s_d[i] = req_i.init ? Iv[255-32*i -: 32] : h_q[255-32*i -: 32];
      for (int i = 0; i < 16; i++) w_d[i] = req_i.block[511-32*i -: 32];
      rnd_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      s_d[7] = s_q[6]; s_d[6] = s_q[5]; s_d[5] = s_q[4]; s_d[4] = s_q[3] + t1;
      s_d[3] = s_q[2]; s_d[2] = s_q[1]; s_d[1] = s_q[0]; s_d[0] = t1 + t2;
      for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
      w_d[15] = wn;
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        for (int i = 0; i < 8; i++) h_d[255-32*i -: 32] = h_q[255-32*i -: 32] + s_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      h_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
      h_q    <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    w_q <= w_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.digest = h_q;
endmodule

[rtl/core/hmac_drbg_sha256_unit.sv]
// top level: hmac_drbg with hmac-sha-256, byte loader and request sequencer
// usage:
//   input channel: valid_i/stall_o with req_type_i, data_byte_i, has_byte_i,
//   req_last_i, out_len_i. each item may carry one byte for the seed buffer
//   (256 bytes); an item is taken whenever the block is idle.
//   the item marked req_last_i starts the request: instantiate, reseed or
//   generate. during the operation stall_o is high.
//   output channel: valid_o/stall_i with out_data_o, out_bytes_o,
//   out_last_o, status_o. generate emits ceil(out_len/8) words, out_len capped
//   at 512 (one when it is zero); the other requests emit a single word.
//   hashing: each sha-256 block is gathered byte by byte and then hashed
//   (start, 64 rounds on the one shared round engine, done); a seed byte
//   needs an extra read state since the seed buffer memory has one
//   registered read port. an hmac is 4 or more blocks, so an update pass
//   is at least 8 blocks, and generate adds one hmac for every 32 output
//   bytes.
//   when the receiver stalls, the word holds and the sequencer waits.
//   reset clears k and v to zero, empties the seed buffer count and flag.
module hmac_drbg_sha256_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        req_last_i,
  input  logic [9:0]  out_len_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_bytes_o,
  output logic        out_last_o,
  output logic        status_o
);
  import hdrbg_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_PLAN, ST_MSG, ST_RD, ST_HASH, ST_WAIT, ST_DIG, ST_OUT, ST_FIN
  } st_e;

  // hmac job kinds
  typedef enum logic [1:0] {
    JOB_UPD_K, JOB_UPD_V, JOB_GEN_V
  } job_e;

  st_e          st_q;
  logic [7:0]   seed_mem [SeedBytes];
  logic [7:0]   rd_q;
  logic [SeedCw-1:0] cnt_q;
  logic         ovf_q;
  logic [255:0] key_q, val_q, inner_q;
  logic [1:0]   type_q;
  logic [LenW-1:0] len_q, made_q;
  logic [1:0]   job_q;
  logic         mark_q, pass2_q, pre_q, outer_q;
  // message stream position of the current sha run, block bytes gathered
  logic [10:0]  pos_q, tot_q;
  logic [511:0] blk_q;
  logic [6:0]   fill_q;
  logic         first_q, padded_q;
  logic [255:0] gen_q;
  logic [2:0]   wsel_q;
  logic         pend_q;
  sha_req_t     sreq;
  sha_rsp_t     srsp;

  hdrbg_sha_core u_sha (.clk_i, .rst_ni, .req_i(sreq), .rsp_o(srsp));

  assign stall_o = (st_q != ST_IDLE);

  // byte at stream position p of the current hash message (data part only)
  logic [7:0] mbyte;
  logic       from_mem;
  logic [10:0] dlen;
  always_comb begin
    mbyte = 8'h00;
    from_mem = 1'b0;
    dlen = 11'd64 + (outer_q ? 11'd32 : (11'd32 + ((job_q == JOB_UPD_K) ?
           11'd1 + 11'(cnt_q) : 11'd0)));
    if (pos_q < 11'd64) begin
      mbyte = (pos_q < 11'd32 ? key_q[255 - 8*pos_q[4:0] -: 8] : 8'h00) ^
              (outer_q ? 8'h5c : 8'h36);
    end else if (pos_q < 11'd96) begin
      mbyte = outer_q ? inner_q[255 - 8*pos_q[4:0] -: 8] : val_q[255 - 8*pos_q[4:0] -: 8];
    end else if (pos_q == 11'd96) begin
      mbyte = mark_q ? 8'h01 : 8'h00;
    end else begin
      from_mem = 1'b1;
    end
  end

  logic [63:0] bitlen;
  assign bitlen = {50'd0, dlen, 3'd0};

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o && has_byte_i && cnt_q < SeedCw'(SeedBytes))
      seed_mem[cnt_q[SeedAw-1:0]] <= data_byte_i;
    rd_q <= seed_mem[8'(pos_q - 11'd97)];
  end

  always_comb begin
    sreq.start = (st_q == ST_HASH);
    sreq.init  = first_q;
    sreq.block = blk_q;
  end

  logic [7:0]  nb;
  always_comb begin
    // next message byte: data, then padding; the length field goes in the last block only
    if (pos_q < dlen) nb = from_mem ? rd_q : mbyte;
    else if (pos_q == dlen) nb = 8'h80;
    else if (fill_q >= 7'd56 && pos_q - 11'(fill_q) + 11'd55 >= dlen)
      nb = bitlen[63 - 8*(fill_q[2:0]) -: 8];
    else nb = 8'h00;
  end

  // current generate word with the bytes past the requested length cleared
  logic [63:0]     gword;
  logic [LenW-1:0] gen_rem;
  always_comb begin
    gen_rem = len_q - made_q;
    gword = gen_q[255 - 64*wsel_q[1:0] -: 64];
    for (int i = 0; i < 8; i++)
      if (LenW'(i) >= gen_rem) gword[63-8*i -: 8] = 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; ovf_q <= 1'b0; key_q <= '0; val_q <= '0;
      valid_o <= 1'b0; pend_q <= 1'b0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (valid_i) begin
            if (has_byte_i) begin
              if (cnt_q < SeedCw'(SeedBytes)) cnt_q <= cnt_q + SeedCw'(1);
              else ovf_q <= 1'b1;
            end
            if (req_last_i) begin
              type_q <= req_type_i;
              len_q <= (out_len_i > LenW'(MaxOutBytes)) ? LenW'(MaxOutBytes) : out_len_i;
              made_q <= '0;
              st_q <= ST_PLAN;
              pre_q <= 1'b1;
              pass2_q <= 1'b0;
              job_q <= JOB_UPD_K;
              // an overflowed request leaves k and v alone
              if (req_type_i == REQ_INST && !ovf_q &&
                  !(has_byte_i && cnt_q >= SeedCw'(SeedBytes))) begin
                key_q <= '0;
                val_q <= {32{8'h01}};
              end
            end
          end
        end
        ST_PLAN: begin
          // choose the next hmac job; an overflowed or unused request goes straight to output
          pos_q <= '0; fill_q <= '0; first_q <= 1'b1; outer_q <= 1'b0;
          padded_q <= 1'b0;
          st_q <= ST_MSG;
          if (ovf_q || type_q == REQ_NONE) begin
            out_data_o <= '0; out_bytes_o <= '0; out_last_o <= 1'b1;
            status_o <= ovf_q; valid_o <= 1'b1; st_q <= ST_OUT;
          end else if (type_q == REQ_GEN && pre_q) begin
            if (cnt_q == '0) begin
              pre_q <= 1'b0; job_q <= JOB_GEN_V; mark_q <= pass2_q;
              if (len_q == '0) begin job_q <= JOB_UPD_K; end
            end else begin
              job_q <= JOB_UPD_K; mark_q <= pass2_q;
            end
          end else if (type_q == REQ_GEN && job_q == JOB_GEN_V) begin
            // generating
          end else begin
            mark_q <= pass2_q;
          end
        end
        ST_MSG: begin
          // gather one byte per cycle; a memory byte first passes through the read state
          if (from_mem && pos_q < dlen && !padded_q) begin
            padded_q <= 1'b1; st_q <= ST_RD;
          end else begin
            padded_q <= 1'b0;
            blk_q <= {blk_q[503:0], nb};
            fill_q <= fill_q + 7'd1;
            pos_q <= pos_q + 11'd1;
            if (fill_q == 7'd63) st_q <= ST_HASH;
          end
        end
        ST_RD: st_q <= ST_MSG;
        ST_HASH: begin
          first_q <= 1'b0;
          fill_q <= '0;
          st_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (srsp.done) begin
            if (pos_q > dlen + 11'd8 || (pos_q > dlen && fill_q == 7'd0 &&
                pos_q[5:0] == 6'd0 && pos_q >= dlen + 11'd9))
              st_q <= ST_DIG;
            else st_q <= ST_MSG;
          end
        end
        ST_DIG: begin
          if (!outer_q) begin
            inner_q <= srsp.digest; outer_q <= 1'b1;
            pos_q <= '0; first_q <= 1'b1; st_q <= ST_MSG;
          end else if (job_q == JOB_UPD_K) begin
            key_q <= srsp.digest; job_q <= JOB_UPD_V;
            pos_q <= '0; first_q <= 1'b1; outer_q <= 1'b0; st_q <= ST_MSG;
          end else if (job_q == JOB_UPD_V) begin
            val_q <= srsp.digest;
            st_q <= ST_PLAN;
            job_q <= JOB_UPD_K;
            if (!pass2_q && cnt_q != '0) pass2_q <= 1'b1;
            else begin
              pass2_q <= 1'b0;
              if (type_q == REQ_GEN && pre_q) begin
                pre_q <= 1'b0;
                if (len_q != '0) job_q <= JOB_GEN_V;
              end else begin
                st_q <= ST_FIN;
              end
            end
          end else begin
            // generate block ready, stream its words out
            val_q <= srsp.digest; gen_q <= srsp.digest; wsel_q <= '0;
            pend_q <= 1'b1; st_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (pend_q) begin
            if (!valid_o || !stall_i) begin
              out_data_o <= gword;
              out_bytes_o <= (gen_rem > LenW'(8)) ? 4'd8 : 4'(gen_rem);
              out_last_o <= (gen_rem <= LenW'(8));
              status_o <= 1'b0; valid_o <= 1'b1;
              made_q <= (gen_rem > LenW'(8)) ? made_q + LenW'(8) : len_q;
              wsel_q <= wsel_q + 3'd1;
              if (gen_rem <= LenW'(8) || wsel_q == 3'd3) begin
                pend_q <= 1'b0;
                st_q <= ST_PLAN;
                if (gen_rem <= LenW'(8)) job_q <= JOB_UPD_K;
              end
            end
          end else if (!valid_o || !stall_i) begin
            // requests without generate words end with one empty last word
            out_data_o <= '0; out_bytes_o <= '0; status_o <= 1'b0;
            out_last_o <= 1'b1;
            valid_o <= !(type_q == REQ_GEN && len_q != '0);
            st_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (valid_o && !stall_i) begin
            valid_o <= 1'b0;
            cnt_q <= '0; ovf_q <= 1'b0;
            st_q <= ST_IDLE;
          end else if (!valid_o) begin
            cnt_q <= '0; ovf_q <= 1'b0; st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
      if (valid_o && !stall_i && st_q != ST_OUT && st_q != ST_FIN) valid_o <= 1'b0;
    end
  end
endmodule

[rtl/core/hdrbg_checker.sv]
// port checker for the hmac drbg unit, attached by bind
module hdrbg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       stall_o,
  input logic       valid_o,
  input logic       stall_i,
  input logic [3:0] out_bytes_o,
  input logic       status_o,
  input logic       req_last_i
);
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_bytes_o <= 4'd8) else $error("byte count too large");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> out_bytes_o == 4'd0) else $error("error with data");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && req_last_i |=> stall_o) else $error("not busy after last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("output dropped");
endmodule

bind hmac_drbg_sha256_unit hdrbg_checker u_chk (.clk_i, .rst_ni, .valid_i, .stall_o,
  .valid_o, .stall_i, .out_bytes_o, .status_o, .req_last_i);

[dv/tb_hmac_drbg_sha256_unit.sv]
// testbench for hmac_drbg_sha256_unit: random requests checked against an hmac-sha-256 drbg predictor
module tb_hmac_drbg_sha256_unit;
  import hdrbg_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // one output word of the block
  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        status;
  } drbg_word_t;

  // predicts k, v and the output words of each request and checks what comes out
  class drbg_scoreboard;
    drbg_word_t   expected_q[$];
    logic [255:0] key_r;
    logic [255:0] val_r;
    logic [7:0]   seed_q[$];
    bit           seed_ovf;
    int           errors;
    int           n_checked;
    logic [31:0]  rc[64];
    logic [31:0]  iv[8];

    function new();
      key_r = '0;
      val_r = '0;
      seed_ovf = 0;
      errors = 0;
      n_checked = 0;
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      rc = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [255:0] sha256(byte_q_t msg);
      byte_q_t      m;
      logic [63:0]  bitlen;
      logic [31:0]  h[8];
      logic [31:0]  w[64];
      logic [31:0]  s[8];
      logic [31:0]  t1;
      logic [31:0]  t2;
      logic [255:0] dig;
      m = msg;
      bitlen = 64'(m.size()) * 8;
      m.push_back(8'h80);
      while (m.size() % 64 != 56) m.push_back(8'h00);
      for (int i = 0; i < 8; i++) m.push_back(bitlen[63-8*i -: 8]);
      h = iv;
      for (int b = 0; b < m.size() / 64; b++) begin
        for (int j = 0; j < 16; j++)
          w[j] = {m[64*b+4*j], m[64*b+4*j+1], m[64*b+4*j+2], m[64*b+4*j+3]};
        for (int j = 16; j < 64; j++)
          w[j] = (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7] +
                 (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
        s = h;
        for (int j = 0; j < 64; j++) begin
          t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25)) +
               ((s[4] & s[5]) ^ (~s[4] & s[6])) + rc[j] + w[j];
          t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22)) +
               ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
          s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
          s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) h[j] = h[j] + s[j];
      end
      for (int j = 0; j < 8; j++) dig[255-32*j -: 32] = h[j];
      return dig;
    endfunction

    function byte_q_t to_bytes(logic [255:0] x);
      byte_q_t q;
      for (int i = 0; i < 32; i++) q.push_back(x[255-8*i -: 8]);
      return q;
    endfunction

    function logic [255:0] hmac(logic [255:0] key, byte_q_t msg);
      byte_q_t q;
      byte_q_t o;
      for (int i = 0; i < 64; i++) q.push_back((i < 32 ? key[255-8*i -: 8] : 8'h00) ^ 8'h36);
      q = {q, msg};
      for (int i = 0; i < 64; i++) o.push_back((i < 32 ? key[255-8*i -: 8] : 8'h00) ^ 8'h5c);
      o = {o, to_bytes(sha256(q))};
      return sha256(o);
    endfunction

    // one pass of the drbg update with separator byte mark
    function void update_pass(logic [7:0] mark, byte_q_t d);
      byte_q_t q;
      q = to_bytes(val_r);
      q.push_back(mark);
      q = {q, d};
      key_r = hmac(key_r, q);
      val_r = hmac(key_r, to_bytes(val_r));
    endfunction

    function void reseed_kv(byte_q_t d);
      update_pass(8'h00, d);
      if (d.size() != 0) update_pass(8'h01, d);
    endfunction

    function void push_word(logic [63:0] data, logic [3:0] nb, logic last, logic st);
      drbg_word_t wd;
      wd.data = data;
      wd.nbytes = nb;
      wd.last = last;
      wd.status = st;
      expected_q.push_back(wd);
    endfunction

    // accepted input item: buffer the byte, and on the last item predict the words
    function void note_item(req_e t, logic [7:0] b, logic has, logic last, logic [9:0] olen);
      int          n;
      int          nres;
      int          cnt;
      byte_q_t     gen;
      logic [63:0] wd;
      if (has) begin
        if (seed_q.size() < SeedBytes) seed_q.push_back(b);
        else seed_ovf = 1;
      end
      if (!last) return;
      if (seed_ovf) begin
        push_word('0, '0, 1'b1, 1'b1);
      end else if (t == REQ_INST || t == REQ_RESEED) begin
        if (t == REQ_INST) begin
          key_r = '0;
          val_r = {32{8'h01}};
        end
        reseed_kv(seed_q);
        push_word('0, '0, 1'b1, 1'b0);
      end else if (t == REQ_GEN) begin
        n = (olen > MaxOutBytes) ? MaxOutBytes : olen;
        if (seed_q.size() != 0) reseed_kv(seed_q);
        while (gen.size() < n) begin
          val_r = hmac(key_r, to_bytes(val_r));
          gen = {gen, to_bytes(val_r)};
        end
        reseed_kv(seed_q);
        nres = (n == 0) ? 1 : (n + 7) / 8;
        for (int r = 0; r < nres; r++) begin
          cnt = n - 8 * r;
          if (cnt > 8) cnt = 8;
          wd = '0;
          for (int i = 0; i < cnt; i++) wd[63-8*i -: 8] = gen[8*r+i];
          push_word(wd, 4'(cnt), r + 1 == nres, 1'b0);
        end
      end else begin
        push_word('0, '0, 1'b1, 1'b0);
      end
      seed_q.delete();
      seed_ovf = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on word %0d: %s got %h expected %h", n_checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [63:0] data, logic [3:0] nb, logic last, logic st);
      drbg_word_t e;
      if (expected_q.size() == 0) begin
        report("unexpected word", data, 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (data !== e.data) report("out_data", data, e.data);
        if (nb !== e.nbytes) report("out_bytes", 64'(nb), 64'(e.nbytes));
        if (last !== e.last) report("out_last", 64'(last), 64'(e.last));
        if (st !== e.status) report("status", 64'(st), 64'(e.status));
      end
      n_checked++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int CycleLimit = 20000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  req_e        req_type_i = REQ_INST;
  logic [7:0]  data_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        req_last_i = 1'b0;
  logic [9:0]  out_len_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [63:0] out_data_o;
  logic [3:0]  out_bytes_o;
  logic        out_last_o;
  logic        status_o;

  drbg_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;

  hmac_drbg_sha256_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .req_type_i(req_type_i), .data_byte_i(data_byte_i), .has_byte_i(has_byte_i),
    .req_last_i(req_last_i), .out_len_i(out_len_i), .valid_o(valid_o),
    .stall_i(stall_i), .out_data_o(out_data_o), .out_bytes_o(out_bytes_o),
    .out_last_o(out_last_o), .status_o(status_o)
  );

  always #6 clk_i = ~clk_i;

  // watchdog: a hung block never finishes its request
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: every accepted word goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      sb.check_result(out_data_o, out_bytes_o, out_last_o, status_o);
  end

  // receiver stall pattern: a random mode is picked whenever the mode counter wraps, plus one long hold-off
  int  hold_cnt = 0;
  bit  hold_done = 0;
  int  stall_mode = 0;
  int  mode_cnt = 0;
  always @(posedge clk_i) begin
    if (!hold_done && sb.n_checked >= 30) begin
      hold_done = 1;
      hold_cnt = 3000;
    end
    if (mode_cnt == 199) begin
      mode_cnt = 0;
      stall_mode = $urandom_range(0, 3);
    end else begin
      mode_cnt++;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: stall_i <= 1'b0;
        1: stall_i <= ($urandom_range(0, 99) < 30);
        2: stall_i <= (mode_cnt % 3 == 0);
        default: stall_i <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // drives one item and waits until the block takes it; gaps come between bursts
  task send_item(req_e t, logic [7:0] b, logic has, logic last, logic [9:0] olen);
    valid_i <= 1'b1;
    req_type_i <= t;
    data_byte_i <= b;
    has_byte_i <= has;
    req_last_i <= last;
    out_len_i <= olen;
    do @(posedge clk_i); while (stall_o);
    sb.note_item(t, b, has, last, olen);
    if (has || last) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      if ($urandom_range(0, 1)) begin
        valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  endtask

  // fill: 0 random bytes, 1 all zero, 2 all ones; noisy adds ignored items and mixed types
  task send_request(req_e t, int nbytes, logic [9:0] olen, int fill, bit noisy);
    logic [7:0] b;
    req_e       ti;
    if (nbytes == 0) begin
      send_item(t, 8'($urandom), 1'b0, 1'b1, olen);
    end else begin
      for (int i = 0; i < nbytes; i++) begin
        b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom);
        ti = (noisy && i + 1 < nbytes) ? req_e'($urandom_range(0, 3)) : t;
        if (noisy && $urandom_range(0, 3) == 0)
          send_item(ti, 8'($urandom), 1'b0, 1'b0, 10'($urandom));
        send_item(ti, b, 1'b1, i + 1 == nbytes, i + 1 == nbytes ? olen : 10'($urandom));
      end
    end
  endtask

  // sender goes idle until every expected word has come out
  task drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int  kind;
    int  nb;
    logic [9:0] ol;
    bit  ovf_done;
    ovf_done = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: generate with zero k and v straight after reset, all-zero additional input
    send_request(REQ_GEN, 2, 10'd16, 1, 0);
    send_request(REQ_INST, 0, 10'd0, 0, 0);              // empty instantiate
    send_request(REQ_INST, 6, 10'd0, 2, 0);              // all-ones seed
    send_request(REQ_GEN, 0, 10'd0, 0, 0);               // zero length generate
    send_request(REQ_GEN, 0, 10'd1, 0, 0);
    send_request(REQ_RESEED, 3, 10'd0, 0, 0);
    send_request(REQ_RESEED, 0, 10'd0, 0, 0);            // empty reseed
    send_request(REQ_NONE, 1, 10'd0, 0, 0);              // unused request type
    send_request(REQ_GEN, 1, 10'h3ff, 0, 0);             // oversized length saturates
    send_request(REQ_GEN, 2, 10'd512, 0, 1);             // mixed types, ignored item
    send_request(REQ_GEN, 0, 10'd13, 0, 0);

    // random part: mostly well-formed requests with random content
    while (items_sent < 220) begin
      if (!ovf_done && items_sent > 120) begin
        ovf_done = 1;
        drain();
        // seed buffer overflow, then a normal request to show k and v held
        send_request(req_e'($urandom_range(0, 2)), SeedBytes + 2, 10'd8, 0, 0);
        send_request(REQ_GEN, 0, 10'd24, 0, 0);
      end
      kind = $urandom_range(0, 9);
      nb = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      ol = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 64));
      if (kind < 8)
        send_request(req_e'($urandom_range(0, 2)), nb, ol, 0, 0);
      else
        send_request(req_e'($urandom_range(0, 3)), nb, ol, 0, 1);
    end

    drain();
    repeat (2000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hdrbg_pkg.sv
rtl/core/hdrbg_sha_core.sv
rtl/core/hmac_drbg_sha256_unit.sv
rtl/core/hdrbg_checker.sv
dv/tb_hmac_drbg_sha256_unit.sv
